### sv/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared constants and types for the go-back-n sender.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int SEQ_W  = 16;
  localparam int DATA_W = 32;

  // input commands
  localparam logic [1:0] CMD_OFFER = 2'd0;
  localparam logic [1:0] CMD_ACK   = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_SENT      = 3'd0;
  localparam logic [2:0] ST_RETX      = 3'd1;
  localparam logic [2:0] ST_REFUSED   = 3'd2;
  localparam logic [2:0] ST_ACK_OK    = 3'd3;
  localparam logic [2:0] ST_ACK_IGN   = 3'd4;
  localparam logic [2:0] ST_TICK_IDLE = 3'd5;

  // register indexes on the config port
  localparam logic REG_TOTAL   = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  // one retransmitted word as read back from the buffer
  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [DATA_W-1:0] data;
    logic              last;
  } retx_word_t;

endpackage

### sv/go_back_n_sender_unit.sv
// ----------------------------------------------------------------------------
// go_back_n_sender_unit
// Go-back-N ARQ sender: window bookkeeping, payload buffer, retransmit.
// ----------------------------------------------------------------------------
// Offers, acks and ticks each give one result word, but a tick that hits the
// timeout replays every outstanding packet (up to WINDOW) instead, oldest first,
// one word per cycle while the output is not stalled, through the buffer's single
// read port; the input is stalled while the burst drains.
// The buffer is a synchronous RAM of WINDOW words, slot = sequence mod WINDOW,
// tracked incrementally by base and next slot pointers.
module go_back_n_sender_unit import gbn_pkg::*; #(
  parameter int WINDOW = 4
) (
  input  logic              clk,
  input  logic              rst,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        command,
  input  logic [DATA_W-1:0] payload,
  input  logic [SEQ_W-1:0]  ack_number,
  // output channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        status,
  output logic [SEQ_W-1:0]  sequence_res,
  output logic [DATA_W-1:0] packet_data,
  output logic              all_done,
  output logic              last,
  // config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(WINDOW - 1);
  localparam logic [SLOT_W-1:0] RESET_SLOT = SLOT_W'(1 % WINDOW);
  localparam logic [CNT_W-1:0]  WIN_C      = CNT_W'(WINDOW);

  // registers
  logic [SEQ_W-1:0]  total_packets;
  logic [SEQ_W-1:0]  timeout_ticks;
  logic [SEQ_W-1:0]  window_base, window_base_next;
  logic [SEQ_W-1:0]  next_sequence, next_sequence_next;
  logic [SEQ_W-1:0]  elapsed_ticks, elapsed_ticks_next;
  logic [SLOT_W-1:0] base_slot, base_slot_next;
  logic [SLOT_W-1:0] next_slot, next_slot_next;

  // combinational
  logic              in_acc;
  logic              out_free;
  logic [SEQ_W:0]    base17, next17, ack17, outstanding;
  logic [SEQ_W-1:0]  elapsed_inc;
  logic [CNT_W-1:0]  diff, nsl;
  logic              wr_en;
  logic              start;
  logic [CNT_W-1:0]  start_count;
  logic [2:0]        res_status;
  logic [SEQ_W-1:0]  res_seq;
  logic [DATA_W-1:0] res_data;
  logic              busy;
  logic              rd_valid;
  retx_word_t        rd_word;
  logic              cfg_wr;

  // ---- config port ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_packets <= 16'd10;
      timeout_ticks <= 16'd5;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_TOTAL:   total_packets <= pwdata[SEQ_W-1:0];
        REG_TIMEOUT: timeout_ticks <= pwdata[SEQ_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TOTAL:   prdata = {16'd0, total_packets};
      REG_TIMEOUT: prdata = {16'd0, timeout_ticks};
      default:     prdata = '0;
    endcase
  end

  // ---- handshake ----
  assign out_free = !out_valid || !out_stall;
  assign in_stall = busy || !out_free;
  assign in_acc   = in_valid && !in_stall;

  // stored 0 stands for sequence 65536
  assign base17 = {window_base == '0, window_base};
  assign next17 = {next_sequence == '0, next_sequence};
  assign ack17  = {1'b0, ack_number};
  assign outstanding = next17 - base17;
  assign diff        = CNT_W'(next17 - ack17 - 1'b1);
  assign nsl         = CNT_W'(next_slot);
  assign elapsed_inc = (elapsed_ticks == '1) ? elapsed_ticks : elapsed_ticks + 1'b1;

  always_comb begin
    window_base_next   = window_base;
    next_sequence_next = next_sequence;
    elapsed_ticks_next = elapsed_ticks;
    base_slot_next     = base_slot;
    next_slot_next     = next_slot;
    wr_en       = 1'b0;
    start       = 1'b0;
    start_count = (outstanding > (SEQ_W + 1)'(WINDOW)) ? WIN_C : outstanding[CNT_W-1:0];
    res_status  = ST_REFUSED;
    res_seq     = '0;
    res_data    = '0;
    case (command)
      CMD_OFFER: begin
        if (outstanding < (SEQ_W + 1)'(WINDOW) && next17 <= {1'b0, total_packets}) begin
          wr_en              = in_acc;
          next_sequence_next = next_sequence + 1'b1;
          next_slot_next     = (next_slot == LAST_SLOT) ? '0 : next_slot + 1'b1;
          res_status         = ST_SENT;
          res_seq            = next_sequence;
          res_data           = payload;
        end
      end
      CMD_ACK: begin
        if (ack17 >= base17 && ack17 < next17) begin
          window_base_next   = ack_number + 1'b1;
          elapsed_ticks_next = '0;
          // new base slot sits diff slots behind the next slot
          if (nsl >= diff) begin
            base_slot_next = SLOT_W'(nsl - diff);
          end else begin
            base_slot_next = SLOT_W'(WIN_C - (diff - nsl));
          end
          res_status = ST_ACK_OK;
        end else begin
          res_status = ST_ACK_IGN;
        end
      end
      CMD_TICK: begin
        res_status = ST_TICK_IDLE;
        if (outstanding == '0) begin
          elapsed_ticks_next = '0;
        end else if (elapsed_inc < timeout_ticks) begin
          elapsed_ticks_next = elapsed_inc;
        end else begin
          elapsed_ticks_next = '0;
          start              = in_acc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base   <= 16'd1;
      next_sequence <= 16'd1;
      elapsed_ticks <= '0;
      base_slot     <= RESET_SLOT;
      next_slot     <= RESET_SLOT;
    end else if (in_acc) begin
      window_base   <= window_base_next;
      next_sequence <= next_sequence_next;
      elapsed_ticks <= elapsed_ticks_next;
      base_slot     <= base_slot_next;
      next_slot     <= next_slot_next;
    end
  end

  gbn_retx #(
    .WINDOW (WINDOW),
    .SLOT_W (SLOT_W),
    .CNT_W  (CNT_W)
  ) u_retx (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_slot     (next_slot),
    .wr_data     (payload),
    .start       (start),
    .start_slot  (base_slot),
    .start_seq   (window_base),
    .start_count (start_count),
    .take        (out_free),
    .busy        (busy),
    .rd_valid    (rd_valid),
    .rd_word     (rd_word)
  );

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((in_acc && !start) || (rd_valid && out_free)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !start) begin
      status       <= res_status;
      sequence_res <= res_seq;
      packet_data  <= res_data;
      all_done     <= {window_base_next == '0, window_base_next} > {1'b0, total_packets};
      last         <= 1'b1;
    end else if (rd_valid && out_free) begin
      status       <= ST_RETX;
      sequence_res <= rd_word.seq;
      packet_data  <= rd_word.data;
      all_done     <= base17 > {1'b0, total_packets};
      last         <= rd_word.last;
    end
  end

endmodule

### sv/gbn_retx.sv
// ----------------------------------------------------------------------------
// gbn_retx
// Unacked payload buffer with the retransmit read sequencer.
// ----------------------------------------------------------------------------
module gbn_retx import gbn_pkg::*; #(
  parameter int WINDOW = 4,
  parameter int SLOT_W = 2,
  parameter int CNT_W  = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_slot,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              start,
  input  logic [SLOT_W-1:0] start_slot,
  input  logic [SEQ_W-1:0]  start_seq,
  input  logic [CNT_W-1:0]  start_count,
  input  logic              take,
  output logic              busy,
  output logic              rd_valid,
  output retx_word_t        rd_word
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  logic [DATA_W-1:0] mem [WINDOW];

  logic [CNT_W-1:0]  remaining;
  logic [SLOT_W-1:0] rd_addr;
  logic [SEQ_W-1:0]  seq;
  logic              pending;
  logic              issue;

  // next read may go out as the pending word is taken
  assign issue    = (remaining != '0) && (!pending || take);
  assign busy     = (remaining != '0) || pending;
  assign rd_valid = pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      pending   <= 1'b0;
    end else begin
      if (start) begin
        remaining <= start_count;
      end else if (issue) begin
        remaining <= remaining - 1'b1;
      end
      if (issue) begin
        pending <= 1'b1;
      end else if (take) begin
        pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rd_addr <= start_slot;
      seq     <= start_seq;
    end else if (issue) begin
      rd_addr <= (rd_addr == LAST_SLOT) ? '0 : rd_addr + 1'b1;
      seq     <= seq + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot] <= wr_data;
    end
    if (issue) begin
      rd_word.data <= mem[rd_addr];
      rd_word.seq  <= seq;
      rd_word.last <= (remaining == CNT_W'(1));
    end
  end

endmodule

### sv/gbn_checker.sv
// ----------------------------------------------------------------------------
// gbn_checker
// Port-level checks on the go-back-n sender, bound to the top level.
// ----------------------------------------------------------------------------
module gbn_checker import gbn_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [2:0]        status,
  input logic [SEQ_W-1:0]  sequence_res,
  input logic [DATA_W-1:0] packet_data,
  input logic              last
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(sequence_res)
      && $stable(packet_data) && $stable(last))
    else $error("stalled output word changed");

  // only sends and retransmits carry a packet
  a_no_pkt: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_SENT && status != ST_RETX |-> sequence_res == '0
      && packet_data == '0)
    else $error("packet fields set on non-packet result");

  // single-word results are always last
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_RETX |-> last)
    else $error("non-burst result without last");

  // a burst word that is not last is followed by the next sequence number
  a_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && status == ST_RETX && !last |=>
      !out_valid || (status == ST_RETX && sequence_res == $past(sequence_res) + 1'b1))
    else $error("retransmit burst broken");

endmodule

bind go_back_n_sender_unit gbn_checker u_gbn_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .sequence_res (sequence_res),
  .packet_data  (packet_data),
  .last         (last)
);

### dv/tb_go_back_n_sender_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_go_back_n_sender_unit
// Self-checking bench for the go-back-n sender: a window tracker predicts each
// result word from the accepted commands, and the output stream is compared
// against it. The run covers directed corner cases, random traffic under
// several idle/stall mixes and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_go_back_n_sender_unit;
  import gbn_pkg::*;

  localparam int WIN = 4;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE = WIN + 6;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 112;

  typedef struct packed {
    logic [2:0]        status;
    logic [SEQ_W-1:0]  seq;
    logic [DATA_W-1:0] data;
    logic              done;
    logic              last;
  } result_word_t;

  // Tracks window state and queues the result words each command must produce.
  class window_tracker;
    int unsigned pkt_total;
    int unsigned retx_after;
    int unsigned oldest;      // stored 16-bit form, 0 stands for 65536
    int unsigned fresh;
    int unsigned idle_ticks;
    logic [DATA_W-1:0] held_payload [WIN];
    result_word_t awaited[$];
    int unsigned failures;

    function new();
      pkt_total = 10;
      retx_after = 5;
      oldest = 1;
      fresh = 1;
      idle_ticks = 0;
      failures = 0;
    endfunction

    function int unsigned seq_of(int unsigned stored);
      return (stored == 0) ? 32'h10000 : stored;
    endfunction

    function int unsigned base_value();
      return seq_of(oldest);
    endfunction

    function int unsigned next_value();
      return seq_of(fresh);
    endfunction

    function void set_reg(logic idx, int unsigned value);
      if (idx == REG_TOTAL) pkt_total = value & 16'hFFFF;
      else retx_after = value & 16'hFFFF;
    endfunction

    function void push(logic [2:0] st, int unsigned seq, logic [DATA_W-1:0] data, bit fin);
      result_word_t w;
      w.status = st;
      w.seq = seq[SEQ_W-1:0];
      w.data = data;
      w.done = base_value() > pkt_total;
      w.last = fin;
      awaited.push_back(w);
    endfunction

    function void note_command(logic [1:0] cmd, logic [DATA_W-1:0] data,
                               logic [SEQ_W-1:0] ack);
      int unsigned b;
      int unsigned n;
      int unsigned count;
      b = base_value();
      n = next_value();
      case (cmd)
        CMD_OFFER: begin
          if (n < b + WIN && n <= pkt_total) begin
            held_payload[n % WIN] = data;
            fresh = (n + 1) & 16'hFFFF;
            push(ST_SENT, n, data, 1'b1);
          end else begin
            push(ST_REFUSED, 0, '0, 1'b1);
          end
        end
        CMD_ACK: begin
          if (ack >= b && ack < n) begin
            oldest = (ack + 1) & 16'hFFFF;
            idle_ticks = 0;
            push(ST_ACK_OK, 0, '0, 1'b1);
          end else begin
            push(ST_ACK_IGN, 0, '0, 1'b1);
          end
        end
        CMD_TICK: begin
          if (n <= b) begin
            idle_ticks = 0;
            push(ST_TICK_IDLE, 0, '0, 1'b1);
          end else begin
            if (idle_ticks < 16'hFFFF) idle_ticks++;
            if (idle_ticks < retx_after) begin
              push(ST_TICK_IDLE, 0, '0, 1'b1);
            end else begin
              // timeout: replay the whole outstanding window, oldest first
              idle_ticks = 0;
              count = n - b;
              if (count > WIN) count = WIN;
              for (int i = 0; i < count; i++)
                push(ST_RETX, b + i, held_payload[(b + i) % WIN], (i + 1 == count));
            end
          end
        end
        default: push(ST_REFUSED, 0, '0, 1'b1);
      endcase
    endfunction

    function void check_word(result_word_t got);
      result_word_t want;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result word: status %0d seq %0d data %h done %b last %b",
                   got.status, got.seq, got.data, got.done, got.last);
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status || got.seq !== want.seq || got.data !== want.data ||
          got.done !== want.done || got.last !== want.last) begin
        failures++;
        if (failures <= 10)
          $display("mismatch (exp/act): status %0d/%0d seq %0d/%0d data %h/%h done %b/%b last %b/%b",
                   want.status, got.status, want.seq, got.seq, want.data, got.data,
                   want.done, got.done, want.last, got.last);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        command = CMD_OFFER;
  logic [DATA_W-1:0] payload = '0;
  logic [SEQ_W-1:0]  ack_number = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        status;
  logic [SEQ_W-1:0]  sequence_res;
  logic [DATA_W-1:0] packet_data;
  logic              all_done;
  logic              last;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  window_tracker tracker = new();

  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  go_back_n_sender_unit #(.WINDOW(WIN)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .payload(payload), .ack_number(ack_number),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .sequence_res(sequence_res), .packet_data(packet_data),
    .all_done(all_done), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random stall, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_word({status, sequence_res, packet_data, all_done, last});
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_word(input logic [1:0] cmd, input logic [DATA_W-1:0] data,
                           input logic [SEQ_W-1:0] ack);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    command <= cmd;
    payload <= data;
    ack_number <= ack;
    do @(posedge clk); while (in_stall);
    tracker.note_command(cmd, data, ack);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.set_reg(idx, value);
    @(posedge clk);
  endtask

  // mostly legal traffic: in-window acks, offers and ticks, plus some noise
  task automatic random_item();
    int unsigned b;
    int unsigned n;
    int unsigned pick;
    int unsigned sel;
    logic [1:0] cmd;
    logic [DATA_W-1:0] data;
    logic [SEQ_W-1:0] ack;
    b = tracker.base_value();
    n = tracker.next_value();
    data = $urandom;
    ack = $urandom;
    if ($urandom_range(99) < 4) data = $urandom_range(1) ? '1 : '0;
    pick = $urandom_range(99);
    if (pick < 45) begin
      cmd = CMD_OFFER;
    end else if (pick < 75) begin
      cmd = CMD_ACK;
      sel = $urandom_range(9);
      if (sel < 7 && n > b) ack = 16'(b + $urandom_range(n - b - 1));
      else if (sel == 7) ack = 16'(b - 1);
      else if (sel == 8) ack = 16'(n);
    end else if (pick < 96) begin
      cmd = CMD_TICK;
    end else begin
      cmd = CMD_UNUSED;
    end
    send_word(cmd, data, ack);
  endtask

  task automatic run_random(input int unsigned items);
    repeat (items) random_item();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, total 10 and timeout 5
    send_word(CMD_TICK, '0, '0);              // nothing outstanding
    send_word(CMD_ACK, '0, 16'd0);            // below base
    send_word(CMD_ACK, '0, 16'd1);            // at next
    send_word(CMD_UNUSED, '1, '1);
    send_word(CMD_OFFER, 32'h0000_0000, '0);
    send_word(CMD_OFFER, 32'hFFFF_FFFF, '1);
    send_word(CMD_OFFER, 32'hA5A5_A5A5, '0);
    send_word(CMD_OFFER, 32'h5A5A_5A5A, '0);
    send_word(CMD_OFFER, 32'h1234_5678, '0);  // window full
    send_word(CMD_ACK, '0, 16'hFFFF);
    repeat (5) send_word(CMD_TICK, '0, '0);   // last one times out
    send_word(CMD_ACK, '0, 16'd2);
    send_word(CMD_OFFER, 32'hDEAD_BEEF, '0);
    send_word(CMD_OFFER, 32'h0F0F_0F0F, '0);
    drain();
    write_reg(REG_TOTAL, 16'd0);
    write_reg(REG_TIMEOUT, 16'd0);
    send_word(CMD_OFFER, 32'h8000_0001, '0);  // nothing left to send
    send_word(CMD_TICK, '0, '0);              // zero timeout replays at once
    send_word(CMD_ACK, '0, 16'd6);
    drain();
    write_reg(REG_TOTAL, 16'd1);
    send_word(CMD_OFFER, 32'h7FFF_FFFE, '0);
    drain();

    // random traffic under different idle and stall mixes
    write_reg(REG_TOTAL, 16'hFFFF);
    write_reg(REG_TIMEOUT, 16'd2);
    hold_requests++;
    run_random(PHASE_ITEMS);
    drain();

    write_reg(REG_TIMEOUT, 16'd1);
    in_idle_pct = 53;
    run_random(PHASE_ITEMS);
    drain();

    write_reg(REG_TIMEOUT, 16'($urandom_range(3, 8)));
    in_idle_pct = 0;
    out_stall_pct = 53;
    run_random(PHASE_ITEMS);
    drain();

    write_reg(REG_TIMEOUT, 16'($urandom_range(1, 4)));
    in_idle_pct = 25;
    out_stall_pct = 25;
    run_random(PHASE_ITEMS);
    drain();

    if (tracker.failures == 0 && tracker.awaited.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
